>>> rtl/core/lsc_pkg.sv
// Shared types and constants for the limited slope calculator.
// No dependencies; used by lsc_div and limited_slope_calculator_unit.
package lsc_pkg;

	localparam int QUO_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam logic [15:0] GAMMA_RESET = 16'd512;

	// one-sided slope divider: |num| << 16 over spacing (x2 with second neighbor)
	localparam int SIDE_NW = 50;
	localparam int SIDE_DW = 34;
	// central slope divider: |dp*wm + dm*wp| over wp + wm
	localparam int CEN_NW = 63;
	localparam int CEN_DW = 31;
	localparam int LIM_W = 40;

	typedef struct packed {
		logic on_boundary;
		logic signed [31:0] pos_center;
		logic signed [31:0] pos_plus;
		logic signed [31:0] pos_minus;
		logic signed [31:0] val_center;
		logic signed [31:0] val_plus;
		logic signed [31:0] val_plus2;
		logic plus2_present;
		logic signed [31:0] val_minus;
		logic signed [31:0] val_minus2;
		logic minus2_present;
	} item_t;

	typedef struct packed {
		logic signed [31:0] slope;
		logic bad_spacing;
		logic saturated;
	} result_t;

	// spacing weights for the central average, scaled below 2^31
	typedef struct packed {
		logic [30:0] wp;
		logic [30:0] wm;
		logic [30:0] ws;
	} wgt_t;

	typedef struct packed {
		logic bnd;
		logic bad;
	} flag_t;

	typedef struct packed {
		logic bnd;
		logic bad;
		logic sat;
		logic pos;
		logic ngs;
		logic [LIM_W-1:0] lim;
	} fin_t;

endpackage

>>> rtl/core/lsc_div.sv
// Pipelined restoring divider, one quotient bit per stage, signed clip to Q16.16.
// Depends on lsc_pkg for the quotient width.
module lsc_div #(
	parameter int NW = lsc_pkg::SIDE_NW,
	parameter int DW = lsc_pkg::SIDE_DW,
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [NW-1:0]        n,
	input  logic [DW-1:0]        d,
	input  logic                 neg,
	input  logic [SW-1:0]        side,
	output logic                 out_valid,
	output logic signed [31:0]   q,
	output logic                 sat,
	output logic [SW-1:0]        out_side
);

	localparam int QW = lsc_pkg::QUO_BITS;
	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic          v_s   [0:QW];
	logic [DW-1:0] rem_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic [QW-1:0] nlo_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic          neg_s [0:QW];
	logic          ovf_s [0:QW];
	logic [SW-1:0] side_s[0:QW];

	logic [CW-1:0] n_x, d_x;

	// quotient needs more than QW bits exactly when n >= d << QW
	assign n_x = CW'(n);
	assign d_x = CW'(d) << QW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= DW'(n_x >> QW);
			den_s[0]  <= d;
			nlo_s[0]  <= n[QW-1:0];
			quo_s[0]  <= '0;
			neg_s[0]  <= neg;
			ovf_s[0]  <= (n_x >= d_x);
			side_s[0] <= side;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_bit
		logic [DW:0] t, diff;
		logic ge;
		assign t    = {rem_s[k], nlo_s[k][QW-1]};
		assign diff = t - {1'b0, den_s[k]};
		assign ge   = (t >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
				den_s[k+1]  <= den_s[k];
				nlo_s[k+1]  <= nlo_s[k] << 1;
				quo_s[k+1]  <= {quo_s[k][QW-2:0], ge};
				neg_s[k+1]  <= neg_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	logic big;
	logic signed [31:0] q_d;
	logic [QW-1:0] qf;

	assign qf = quo_s[QW];

	always_comb begin
		if (neg_s[QW]) begin
			big = ovf_s[QW] | (qf[QW-1] & (|qf[QW-2:0]));
			q_d = big ? {1'b1, 31'b0} : -$signed(qf);
		end else begin
			big = ovf_s[QW] | qf[QW-1];
			q_d = big ? {1'b0, {31{1'b1}}} : $signed(qf);
		end
	end

	logic          ov_q;
	logic signed [31:0] q_q;
	logic          sat_q;
	logic [SW-1:0] side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_q    <= q_d;
			sat_q  <= big;
			side_q <= side_s[QW];
		end
	end

	assign out_valid = ov_q;
	assign q         = q_q;
	assign sat       = sat_q;
	assign out_side  = side_q;

endmodule

>>> rtl/core/limited_slope_calculator_unit.sv
// Limited slope calculator: MUSCL minmod-type slope along one axis, Q16.16.
// Depends on lsc_pkg and lsc_div.
//
// Channels: item (item_valid/item_ready, lsc_pkg::item_t) in, result
// (result_valid/result_ready, lsc_pkg::result_t) out, and cfg (cfg_valid/
// cfg_ready, cfg_data) which writes limiter_gamma; cfg_ready is always high.
// The path from item transfer to result_valid: three input stages,
// a 34-stage divider pair for the one-sided slopes, three stages for the
// weighted sum and gamma scaling, a 34-stage divider for the central slope and
// the result register. Throughput is one item per cycle while no stall holds
// the pipeline; each divider stage resolves one quotient bit.
// All stages advance together; when the result register holds an untaken
// result and the last divider stage carries an item, the pipeline and
// item_ready hold until result_ready. Bubbles ahead of the result still move.
// Reset clears the valid bits and sets limiter_gamma to 2.0 (512).
module limited_slope_calculator_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  lsc_pkg::item_t      item,
	output logic                result_valid,
	input  logic                result_ready,
	output lsc_pkg::result_t    result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);

	logic [15:0] gamma_q;
	logic adv, v_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= lsc_pkg::GAMMA_RESET;
		end else if (cfg_valid) begin
			gamma_q <= cfg_data;
		end
	end

	// ---- s1: spacings and value differences
	logic v_s1, bnd_s1, p2_s1, m2_s1;
	logic signed [32:0] dxp_s1, dxm_s1, dp1_s1, dp2_s1, dm1_s1, dm2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bnd_s1 <= item.on_boundary;
			p2_s1  <= item.plus2_present;
			m2_s1  <= item.minus2_present;
			dxp_s1 <= 33'(item.pos_plus) - 33'(item.pos_center);
			dxm_s1 <= 33'(item.pos_center) - 33'(item.pos_minus);
			dp1_s1 <= 33'(item.val_plus) - 33'(item.val_center);
			dp2_s1 <= 33'(item.val_plus2) - 33'(item.val_center);
			dm1_s1 <= 33'(item.val_center) - 33'(item.val_minus);
			dm2_s1 <= 33'(item.val_center) - 33'(item.val_minus2);
		end
	end

	// ---- s2: numerators, denominators, central weights
	logic v_s2, bnd_s2, bad_s2;
	logic signed [33:0] nump_s2, numm_s2;
	logic [33:0] denp_s2, denm_s2;
	lsc_pkg::wgt_t wgt_s2, wgt_d;
	logic [32:0] ux, uy;
	logic [33:0] sh0, sh1, sh2;

	assign ux  = dxp_s1;
	assign uy  = dxm_s1;
	assign sh0 = 34'(ux) + 34'(uy);
	assign sh1 = 34'(ux >> 1) + 34'(uy >> 1);
	assign sh2 = 34'(ux >> 2) + 34'(uy >> 2);

	// halve both spacings until their sum fits below 2^31 (at most twice)
	always_comb begin
		if (sh0[33:31] == 3'b000) begin
			wgt_d = '{wp: ux[30:0], wm: uy[30:0], ws: sh0[30:0]};
		end else if (sh1[33:31] == 3'b000) begin
			wgt_d = '{wp: ux[31:1], wm: uy[31:1], ws: sh1[30:0]};
		end else begin
			wgt_d = '{wp: ux[32:2], wm: uy[32:2], ws: sh2[30:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bnd_s2  <= bnd_s1;
			bad_s2  <= (dxp_s1 <= 33'sd0) | (dxm_s1 <= 33'sd0);
			nump_s2 <= p2_s1 ? 34'(dp1_s1) + 34'(dp2_s1) : 34'(dp1_s1);
			numm_s2 <= m2_s1 ? 34'(dm1_s1) + 34'(dm2_s1) : 34'(dm1_s1);
			denp_s2 <= p2_s1 ? {ux, 1'b0} : {1'b0, ux};
			denm_s2 <= m2_s1 ? {uy, 1'b0} : {1'b0, uy};
			wgt_s2  <= wgt_d;
		end
	end

	// ---- s3: magnitudes scaled to Q16.16 for the dividers
	logic v_s3, negp_s3, negm_s3;
	logic [lsc_pkg::SIDE_NW-1:0] np_s3, nm_s3;
	logic [33:0] denp_s3, denm_s3;
	lsc_pkg::wgt_t wgt_s3;
	lsc_pkg::flag_t flg_s3;
	logic [33:0] magp, magm;

	assign magp = nump_s2[33] ? 34'(-nump_s2) : 34'(nump_s2);
	assign magm = numm_s2[33] ? 34'(-numm_s2) : 34'(numm_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			np_s3   <= {magp, {lsc_pkg::FRAC_BITS{1'b0}}};
			nm_s3   <= {magm, {lsc_pkg::FRAC_BITS{1'b0}}};
			negp_s3 <= nump_s2[33];
			negm_s3 <= numm_s2[33];
			denp_s3 <= denp_s2;
			denm_s3 <= denm_s2;
			wgt_s3  <= wgt_s2;
			flg_s3  <= '{bnd: bnd_s2, bad: bad_s2};
		end
	end

	// ---- one-sided slopes
	logic vp_o, vm_o, satp_o, satm_o;
	logic signed [31:0] dp_o, dm_o;
	lsc_pkg::wgt_t wgt_o;
	lsc_pkg::flag_t flg_o;

	lsc_div #(
		.NW(lsc_pkg::SIDE_NW), .DW(lsc_pkg::SIDE_DW), .SW($bits(lsc_pkg::wgt_t))
	) u_div_p (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s3),
		.n(np_s3), .d(denp_s3), .neg(negp_s3), .side(wgt_s3),
		.out_valid(vp_o), .q(dp_o), .sat(satp_o), .out_side(wgt_o)
	);

	lsc_div #(
		.NW(lsc_pkg::SIDE_NW), .DW(lsc_pkg::SIDE_DW), .SW($bits(lsc_pkg::flag_t))
	) u_div_m (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s3),
		.n(nm_s3), .d(denm_s3), .neg(negm_s3), .side(flg_s3),
		.out_valid(vm_o), .q(dm_o), .sat(satm_o), .out_side(flg_o)
	);

	// ---- s4: weighted products and gamma scaling
	logic v_s4, pos_s4, ngs_s4, sat_s4;
	logic signed [63:0] prp_s4, prm_s4;
	logic [lsc_pkg::LIM_W-1:0] lp_s4, lm_s4;
	logic [30:0] ws_s4;
	lsc_pkg::flag_t flg_s4;
	logic [31:0] mp, mm;
	logic [47:0] gp, gm;
	logic signed [63:0] prp, prm;

	assign mp  = dp_o[31] ? 32'(-dp_o) : 32'(dp_o);
	assign mm  = dm_o[31] ? 32'(-dm_o) : 32'(dm_o);
	assign gp  = mp * gamma_q;
	assign gm  = mm * gamma_q;
	assign prp = dp_o * $signed({1'b0, wgt_o.wm});
	assign prm = dm_o * $signed({1'b0, wgt_o.wp});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= vp_o & vm_o;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prp_s4 <= prp;
			prm_s4 <= prm;
			lp_s4  <= gp[47:8];
			lm_s4  <= gm[47:8];
			pos_s4 <= (dp_o > 32'sd0) & (dm_o > 32'sd0);
			ngs_s4 <= dp_o[31] & dm_o[31];
			sat_s4 <= satp_o | satm_o;
			ws_s4  <= wgt_o.ws;
			flg_s4 <= flg_o;
		end
	end

	// ---- s5: weighted sum, smaller one-sided limit
	logic v_s5;
	logic signed [63:0] sum_s5;
	logic [30:0] ws_s5;
	lsc_pkg::fin_t fin_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s5 <= prp_s4 + prm_s4;
			ws_s5  <= ws_s4;
			fin_s5 <= '{bnd: flg_s4.bnd, bad: flg_s4.bad, sat: sat_s4,
				pos: pos_s4, ngs: ngs_s4, lim: (lm_s4 < lp_s4) ? lm_s4 : lp_s4};
		end
	end

	// ---- s6: magnitude for the central divider
	logic v_s6, neg_s6;
	logic [lsc_pkg::CEN_NW-1:0] n_s6;
	logic [30:0] ws_s6;
	lsc_pkg::fin_t fin_s6;
	logic [63:0] msum;

	assign msum = sum_s5[63] ? 64'(-sum_s5) : 64'(sum_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s6   <= msum[lsc_pkg::CEN_NW-1:0];
			neg_s6 <= sum_s5[63];
			ws_s6  <= ws_s5;
			fin_s6 <= fin_s5;
		end
	end

	// ---- central slope
	logic vd_o, dcsat_o;
	logic signed [31:0] dc_o;
	lsc_pkg::fin_t fin_o;

	lsc_div #(
		.NW(lsc_pkg::CEN_NW), .DW(lsc_pkg::CEN_DW), .SW($bits(lsc_pkg::fin_t))
	) u_div_c (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s6),
		.n(n_s6), .d(ws_s6), .neg(neg_s6), .side(fin_s6),
		.out_valid(vd_o), .q(dc_o), .sat(dcsat_o), .out_side(fin_o)
	);

	// ---- final limit and special cases
	lsc_pkg::result_t res_d, result_q;
	logic result_valid_q;
	logic [31:0] mdc;
	logic [lsc_pkg::LIM_W-1:0] lim2;

	assign mdc  = dc_o[31] ? 32'(-dc_o) : 32'(dc_o);
	assign lim2 = (lsc_pkg::LIM_W'(mdc) < fin_o.lim) ? lsc_pkg::LIM_W'(mdc) : fin_o.lim;

	always_comb begin
		res_d = '{slope: 32'sd0, bad_spacing: 1'b0, saturated: 1'b0};
		if (fin_o.bnd) begin
			res_d = '{slope: 32'sd0, bad_spacing: 1'b0, saturated: 1'b0};
		end else if (fin_o.bad) begin
			res_d = '{slope: 32'sd0, bad_spacing: 1'b1, saturated: 1'b0};
		end else begin
			res_d.saturated = fin_o.sat | dcsat_o;
			// lim2 never exceeds |dc| <= 2^31
			if (fin_o.pos) begin
				if (lim2[31]) begin
					res_d.slope     = {1'b0, {31{1'b1}}};
					res_d.saturated = 1'b1;
				end else begin
					res_d.slope = $signed(lim2[31:0]);
				end
			end else if (fin_o.ngs) begin
				res_d.slope = -$signed(lim2[31:0]);
			end
		end
	end

	assign v_last     = vd_o;
	assign adv        = !result_valid_q | result_ready | !v_last;
	assign item_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv & v_last) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv & v_last) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
